/* hw/rtl/ntpn_pkg.sv */
package ntpn_pkg;

    localparam int NUM_W        = 64;   // binary input width
    localparam int DIGITS       = 20;   // decimal digits of the largest input
    localparam int BCD_W        = 4 * DIGITS;
    localparam int CODE_W       = 6;    // packed code per digit
    localparam int CODE_BASE    = 2;    // bit position of the first code
    localparam int DIGIT_OFS    = 2;    // code = digit + offset
    localparam int NAME_W       = 128;
    localparam int HALF_W       = 64;
    localparam int CNT_W        = 5;
    localparam int TAG_W        = 2;
    localparam int DABBLE_STEPS = 8;    // shift-add-3 steps per stage, divides NUM_W

    typedef enum logic [TAG_W-1:0] {
        LEN_1_5   = 2'd0,
        LEN_6_10  = 2'd1,
        LEN_11_15 = 2'd2,
        LEN_16_20 = 2'd3
    } t_len_tag;

endpackage

/* hw/rtl/ntpn_if.sv */
interface ntpn_num_if;
    logic                        valid;
    logic                        ready;
    logic [ntpn_pkg::NUM_W-1:0]  number;

    modport source (output valid, output number, input ready);
    modport sink   (input valid, input number, output ready);
endinterface

interface ntpn_name_if;
    logic                        valid;
    logic                        ready;
    logic [ntpn_pkg::HALF_W-1:0] name_high;
    logic [ntpn_pkg::HALF_W-1:0] name_low;
    logic [ntpn_pkg::CNT_W-1:0]  digit_count;

    modport source (output valid, output name_high, output name_low, output digit_count,
                    input ready);
    modport sink   (input valid, input name_high, input name_low, input digit_count,
                    output ready);
endinterface

/* hw/rtl/number_to_packed_name.sv */
// Channel  | Dir | Payload                                | Accepted when
// ---------+-----+----------------------------------------+------------------
// i_num    | in  | number[63:0]                           | valid && ready
// o_name   | out | name_high[63:0] name_low[63:0] cnt[4:0] | valid && ready
//
// One item enters per cycle while o_name is not stalled; the shift-add-3 chain is
// cut into stages of DABBLE_STEPS bit steps, then one stage counts digits and one
// packs the codes into the output register.
// Synchronous active-low reset clears every stage valid bit; data registers hold.
// A stall at o_name backs up stage by stage; an empty stage still loads, so
// bubbles close up and no item is lost or repeated.
module number_to_packed_name #(
    parameter int DABBLE_STEPS = ntpn_pkg::DABBLE_STEPS
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    ntpn_num_if.sink      i_num,
    ntpn_name_if.source   o_name
);

    localparam int STAGES = ntpn_pkg::NUM_W / DABBLE_STEPS;

    // chain between double-dabble stages; index 0 is the input
    logic                       w_vld  [STAGES+1];
    logic [ntpn_pkg::NUM_W-1:0] w_bin  [STAGES+1];
    logic [ntpn_pkg::BCD_W-1:0] w_bcd  [STAGES+1];
    logic                       w_load [STAGES+1];

    // digit count stage
    logic                       r_c_vld;
    logic [ntpn_pkg::BCD_W-1:0] r_c_bcd;
    logic [ntpn_pkg::CNT_W-1:0] r_c_cnt;
    logic [ntpn_pkg::CNT_W-1:0] n_c_cnt;
    logic                       w_c_load;

    // output stage
    logic                        r_o_vld;
    logic [ntpn_pkg::NAME_W-1:0] r_o_name;
    logic [ntpn_pkg::CNT_W-1:0]  r_o_cnt;
    logic [ntpn_pkg::NAME_W-1:0] n_o_name;
    ntpn_pkg::t_len_tag          n_o_tag;
    logic                        w_o_load;

    assign w_vld[0] = i_num.valid;
    assign w_bin[0] = i_num.number;
    assign w_bcd[0] = '0;

    // a stage loads when it is empty or its item moves on
    assign w_o_load      = !r_o_vld || o_name.ready;
    assign w_c_load      = !r_c_vld || w_o_load;
    assign w_load[STAGES] = w_c_load;
    assign i_num.ready   = w_load[0];

    for (genvar g = 0; g < STAGES; g++) begin : g_dabble
        assign w_load[g] = !w_vld[g+1] || w_load[g+1];

        ntpn_dabble #(
            .STEPS (DABBLE_STEPS)
        ) u_dabble (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_load  (w_load[g]),
            .i_valid (w_vld[g]),
            .i_bin   (w_bin[g]),
            .i_bcd   (w_bcd[g]),
            .o_valid (w_vld[g+1]),
            .o_bin   (w_bin[g+1]),
            .o_bcd   (w_bcd[g+1])
        );
    end

    // digit count: position of the highest nonzero digit, at least one
    always_comb begin
        n_c_cnt = ntpn_pkg::CNT_W'(1);
        for (int k = 0; k < ntpn_pkg::DIGITS; k++) begin
            if (w_bcd[STAGES][4*k +: 4] != 4'd0) begin
                n_c_cnt = ntpn_pkg::CNT_W'(k + 1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_vld <= 1'b0;
        end else if (w_c_load) begin
            r_c_vld <= w_vld[STAGES];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_c_load) begin
            r_c_bcd <= w_bcd[STAGES];
            r_c_cnt <= n_c_cnt;
        end
    end

    // pack: most significant digit lowest, unused slots stay zero
    always_comb begin
        n_o_name = '0;
        for (int k = 0; k < ntpn_pkg::DIGITS; k++) begin
            for (int j = 0; j < ntpn_pkg::DIGITS; j++) begin
                if ((k < int'(r_c_cnt)) && (j == int'(r_c_cnt) - 1 - k)) begin
                    n_o_name[ntpn_pkg::CODE_BASE + ntpn_pkg::CODE_W*k +: ntpn_pkg::CODE_W] =
                        ntpn_pkg::CODE_W'(r_c_bcd[4*j +: 4]) +
                        ntpn_pkg::CODE_W'(ntpn_pkg::DIGIT_OFS);
                end
            end
        end
        case (r_c_cnt) inside
            [5'd1:5'd5]:   n_o_tag = ntpn_pkg::LEN_1_5;
            [5'd6:5'd10]:  n_o_tag = ntpn_pkg::LEN_6_10;
            [5'd11:5'd15]: n_o_tag = ntpn_pkg::LEN_11_15;
            default:       n_o_tag = ntpn_pkg::LEN_16_20;
        endcase
        n_o_name[ntpn_pkg::TAG_W-1:0] = n_o_tag;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else if (w_o_load) begin
            r_o_vld <= r_c_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_o_load) begin
            r_o_name <= n_o_name;
            r_o_cnt  <= r_c_cnt;
        end
    end

    assign o_name.valid       = r_o_vld;
    assign o_name.name_high   = r_o_name[ntpn_pkg::NAME_W-1:ntpn_pkg::HALF_W];
    assign o_name.name_low    = r_o_name[ntpn_pkg::HALF_W-1:0];
    assign o_name.digit_count = r_o_cnt;

    // count stays within one to twenty digits
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_vld |-> (r_o_cnt >= 5'd1 && r_o_cnt <= 5'd20))
        else $error("digit count out of range");

    // twenty digits never reach the top code slot
    a_top_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_vld |-> (r_o_name[ntpn_pkg::NAME_W-1:122] == '0))
        else $error("bits above the last digit slot set");

    // a multi-digit name never starts with a zero digit
    a_lead_digit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_vld && r_o_cnt > 5'd1) |->
        (r_o_name[ntpn_pkg::CODE_BASE +: ntpn_pkg::CODE_W] != 6'd2))
        else $error("leading zero digit packed");

    // hold the count stage while the output is stalled
    a_cnt_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_c_vld && r_o_vld && !o_name.ready) |=> (r_c_vld && $stable(r_c_cnt)))
        else $error("count stage moved during stall");

endmodule

/* hw/rtl/ntpn_dabble.sv */
module ntpn_dabble #(
    parameter int STEPS = ntpn_pkg::DABBLE_STEPS
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_load,
    input  logic                       i_valid,
    input  logic [ntpn_pkg::NUM_W-1:0] i_bin,
    input  logic [ntpn_pkg::BCD_W-1:0] i_bcd,
    output logic                       o_valid,
    output logic [ntpn_pkg::NUM_W-1:0] o_bin,
    output logic [ntpn_pkg::BCD_W-1:0] o_bcd
);

    logic                       r_valid;
    logic [ntpn_pkg::NUM_W-1:0] r_bin;
    logic [ntpn_pkg::BCD_W-1:0] r_bcd;
    logic [ntpn_pkg::NUM_W-1:0] n_bin;
    logic [ntpn_pkg::BCD_W-1:0] n_bcd;

    // correct each digit, then shift the next binary bit in
    always_comb begin
        n_bcd = i_bcd;
        n_bin = i_bin;
        for (int s = 0; s < STEPS; s++) begin
            for (int d = 0; d < ntpn_pkg::DIGITS; d++) begin
                if (n_bcd[4*d +: 4] >= 4'd5) begin
                    n_bcd[4*d +: 4] = n_bcd[4*d +: 4] + 4'd3;
                end
            end
            {n_bcd, n_bin} = {n_bcd[ntpn_pkg::BCD_W-2:0], n_bin, 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_bin <= n_bin;
            r_bcd <= n_bcd;
        end
    end

    assign o_valid = r_valid;
    assign o_bin   = r_bin;
    assign o_bcd   = r_bcd;

endmodule

/* tb/tb_number_to_packed_name.sv */
`timescale 1ns / 1ps

module tb_number_to_packed_name;

    localparam int CLK_HALF    = 5;
    localparam int RAND_ITEMS  = 600;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_WAIT  = 30;
    localparam int CYCLE_LIMIT = 200000;

    // One packed decimal name as it leaves the block.
    typedef struct packed {
        logic [ntpn_pkg::HALF_W-1:0] name_high;
        logic [ntpn_pkg::HALF_W-1:0] name_low;
        logic [ntpn_pkg::CNT_W-1:0]  digit_count;
    } t_name;

    // One directed row: the number, and a hand-typed name where it is obvious.
    typedef struct packed {
        logic [ntpn_pkg::NUM_W-1:0] number;
        bit                         typed;
        t_name                      name;
    } t_dir_row;

    logic i_clk;
    logic i_rst_n;

    ntpn_num_if  num_if ();
    ntpn_name_if name_if ();

    number_to_packed_name dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_num   (num_if),
        .o_name  (name_if)
    );

    t_name    pending_names[$];
    t_dir_row dir_rows[$];
    int       mismatch_count = 0;
    int       cycle_count    = 0;
    int       snd_idle_pct   = 0;
    int       rcv_idle_pct   = 0;
    bit       hold_req       = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // Stop a hung run; the budget covers every item waiting out both sides' idling.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $error("timeout after %0d cycles, %0d names still pending",
                   cycle_count, pending_names.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Predict the packed name: decimal digits, most significant first, each coded
    // as digit + offset in a 6-bit slot starting at bit 2, length tag in bits 1:0.
    function automatic t_name pack_decimal_name(input logic [ntpn_pkg::NUM_W-1:0] value);
        t_name                       res;
        logic [ntpn_pkg::NAME_W-1:0] packed_name;
        logic [ntpn_pkg::NUM_W-1:0]  rest;
        logic [3:0]                  dec[ntpn_pkg::DIGITS];
        int                          n;
        int                          k;
        ntpn_pkg::t_len_tag          tag;
        rest        = value;
        n           = 0;
        packed_name = '0;
        do begin
            dec[n] = 4'(rest % 64'd10);
            rest   = rest / 64'd10;
            n++;
        end while (rest != 0 && n < ntpn_pkg::DIGITS);
        for (k = 0; k < n; k++) begin
            packed_name[ntpn_pkg::CODE_BASE + ntpn_pkg::CODE_W * k +: ntpn_pkg::CODE_W] =
                ntpn_pkg::CODE_W'(dec[n - 1 - k] + ntpn_pkg::DIGIT_OFS);
        end
        if (n <= 5) begin
            tag = ntpn_pkg::LEN_1_5;
        end else if (n <= 10) begin
            tag = ntpn_pkg::LEN_6_10;
        end else if (n <= 15) begin
            tag = ntpn_pkg::LEN_11_15;
        end else begin
            tag = ntpn_pkg::LEN_16_20;
        end
        packed_name[ntpn_pkg::TAG_W-1:0] = tag;
        res.name_high   = packed_name[ntpn_pkg::NAME_W-1:ntpn_pkg::HALF_W];
        res.name_low    = packed_name[ntpn_pkg::HALF_W-1:0];
        res.digit_count = ntpn_pkg::CNT_W'(n);
        return res;
    endfunction

    function automatic void add_row(input logic [ntpn_pkg::NUM_W-1:0]  num,
                                    input bit                          typed = 1'b0,
                                    input logic [ntpn_pkg::HALF_W-1:0] hi = '0,
                                    input logic [ntpn_pkg::HALF_W-1:0] lo = '0,
                                    input logic [ntpn_pkg::CNT_W-1:0]  cnt = '0);
        t_dir_row row;
        row.number           = num;
        row.typed            = typed;
        row.name.name_high   = hi;
        row.name.name_low    = lo;
        row.name.digit_count = cnt;
        dir_rows.push_back(row);
    endfunction

    // Mix magnitudes so every digit count and every length tag shows up often.
    function automatic logic [ntpn_pkg::NUM_W-1:0] rand_number();
        logic [ntpn_pkg::NUM_W-1:0] v;
        v = {$urandom, $urandom};
        case ($urandom_range(3))
            0: v = v >> $urandom_range(ntpn_pkg::NUM_W - 1);
            1: v = ntpn_pkg::NUM_W'($urandom_range(999999));
            default: ;
        endcase
        return v;
    endfunction

    // Offer one number, idling first at the current rate; valid stays high after
    // acceptance so back-to-back items never drop it.
    task automatic send_number(input logic [ntpn_pkg::NUM_W-1:0] num, input bit typed,
                               input t_name typed_name);
        while ($urandom_range(99) < snd_idle_pct) begin
            num_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        num_if.valid  <= 1'b1;
        num_if.number <= num;
        do @(posedge i_clk); while (num_if.ready !== 1'b1);
        pending_names.push_back(typed ? typed_name : pack_decimal_name(num));
    endtask

    // Drive the result side's ready; on request, hold off for a long stretch so
    // the pipeline fills and back-pressures the input.
    initial begin
        name_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                name_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
            end
            name_if.ready <= ($urandom_range(99) >= rcv_idle_pct);
        end
    end

    // Compare each accepted name against the oldest expectation.
    always @(posedge i_clk) begin
        t_name want;
        if (i_rst_n === 1'b1 && name_if.valid === 1'b1 && name_if.ready === 1'b1) begin
            if (pending_names.size() == 0) begin
                $error("name out with nothing pending: high %h low %h count %0d",
                       name_if.name_high, name_if.name_low, name_if.digit_count);
                mismatch_count++;
            end else begin
                want = pending_names.pop_front();
                if (name_if.name_high !== want.name_high) begin
                    $error("name_high: expected %h, got %h", want.name_high, name_if.name_high);
                    mismatch_count++;
                end
                if (name_if.name_low !== want.name_low) begin
                    $error("name_low: expected %h, got %h", want.name_low, name_if.name_low);
                    mismatch_count++;
                end
                if (name_if.digit_count !== want.digit_count) begin
                    $error("digit_count: expected %0d, got %0d",
                           want.digit_count, name_if.digit_count);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin
        t_name none;
        int    phase;
        int    i;
        none = '0;

        i_rst_n       <= 1'b0;
        num_if.valid  <= 1'b0;
        num_if.number <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Zero, one digit, first two-digit value, first six-digit value: typed in.
        add_row(64'd0,      1'b1, 64'h0, 64'h8,         5'd1);
        add_row(64'd9,      1'b1, 64'h0, 64'h2c,        5'd1);
        add_row(64'd10,     1'b1, 64'h0, 64'h20c,       5'd2);
        add_row(64'd100000, 1'b1, 64'h0, 64'h20820820d, 5'd6);
        // Tag boundaries, largest value, and alternating bit patterns.
        add_row(64'd1);
        add_row(64'd99999);
        add_row(64'd999999);
        add_row(64'd9999999999);
        add_row(64'd10000000000);
        add_row(64'd999999999999999);
        add_row(64'd1000000000000000);
        add_row(64'd9999999999999999999);
        add_row(64'd10000000000000000000);
        add_row(64'd12345678901234567890);
        add_row(64'hffff_ffff_ffff_ffff);
        add_row(64'h8000_0000_0000_0000);
        add_row(64'h7fff_ffff_ffff_ffff);
        add_row(64'h5555_5555_5555_5555);
        add_row(64'haaaa_aaaa_aaaa_aaaa);
        add_row(64'h0000_0001_0000_0000);
        add_row(64'h0000_0000_ffff_ffff);

        snd_idle_pct = 27;
        rcv_idle_pct = 63;
        foreach (dir_rows[r]) begin
            send_number(dir_rows[r].number, dir_rows[r].typed, dir_rows[r].name);
        end

        // Three phases of random numbers: sender idles less, then more, then never.
        for (phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    snd_idle_pct = 27;
                    rcv_idle_pct = 63;
                end
                1: begin
                    snd_idle_pct = 63;
                    rcv_idle_pct = 27;
                end
                default: begin
                    snd_idle_pct = 0;
                    rcv_idle_pct = 0;
                    hold_req     = 1'b1;
                end
            endcase
            for (i = 0; i < RAND_ITEMS / 3; i++) begin
                send_number(rand_number(), 1'b0, none);
            end
        end
        num_if.valid <= 1'b0;

        while (pending_names.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

/* filelist.f */
hw/rtl/ntpn_pkg.sv
hw/rtl/ntpn_if.sv
hw/rtl/ntpn_dabble.sv
hw/rtl/number_to_packed_name.sv
tb/tb_number_to_packed_name.sv
